FILE: sv/wsd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Window spread detector package
// Shared register codes, fixed field widths, state types and the control
// struct that the top level sends to each monotonic queue.
// ----------------------------------------------------------------------------
package wsd_pkg;

  // Fixed widths of the configuration registers and of the configuration port.
  localparam int unsigned WinLenW  = 11;
  localparam int unsigned SpreadW  = 16;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 16;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_WINDOW_LEN = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_MAX_SPREAD = 1'b1;

  // Top level sequencer states.
  typedef enum logic [1:0] {
    CTL_IDLE,
    CTL_WAIT,
    CTL_EVAL
  } ctl_state_e;

  // Queue engine states.
  typedef enum logic [2:0] {
    Q_IDLE,
    Q_EXP,
    Q_POP,
    Q_WRITE,
    Q_HEAD
  } q_state_e;

  // Commands from the top level to a queue engine.
  typedef struct packed {
    logic start;
    logic clear;
  } qctl_t;

endpackage
`default_nettype wire

FILE: sv/wsd_ifs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Window spread detector channel interfaces
// Valid/ready channels for the sample stream and for the result stream.
// ----------------------------------------------------------------------------
interface wsd_smp_if #(
  parameter int unsigned SAMPLE_WIDTH = 16
) ();
  logic                    valid;
  logic                    ready;
  logic [SAMPLE_WIDTH-1:0] sample;
  logic                    last_sample;

  modport source (output valid, sample, last_sample, input ready);
  modport sink   (input valid, sample, last_sample, output ready);
endinterface

interface wsd_res_if #(
  parameter int unsigned POSITION_WIDTH = 20
) ();
  logic                      valid;
  logic                      ready;
  logic [POSITION_WIDTH-1:0] window_start;
  logic                      none_found;

  modport source (output valid, window_start, none_found, input ready);
  modport sink   (input valid, window_start, none_found, output ready);
endinterface
`default_nettype wire

FILE: sv/wsd_mono_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Window spread detector monotonic queue
// A circular queue of (value, position) entries held in a synchronous RAM.
// For each request it expires old head entries, pops tail entries that the
// new sample dominates, appends the new sample and reports the head value.
// ----------------------------------------------------------------------------
module wsd_mono_queue #(
  parameter int unsigned MAX_WINDOW     = 1024,
  parameter int unsigned POSITION_WIDTH = 20,
  parameter int unsigned SAMPLE_WIDTH   = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               keep_min_i,
  input  wsd_pkg::qctl_t                     ctl_i,
  input  logic [SAMPLE_WIDTH-1:0]            value_i,
  input  logic [POSITION_WIDTH-1:0]          pos_i,
  input  logic [$clog2(MAX_WINDOW + 1)-1:0]  len_i,
  output logic                               done_o,
  output logic [SAMPLE_WIDTH-1:0]            head_value_o
);
  import wsd_pkg::*;

  localparam int unsigned AddrW  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned CntW   = $clog2(MAX_WINDOW + 1);
  localparam int unsigned EntryW = SAMPLE_WIDTH + POSITION_WIDTH;
  localparam int unsigned SumW   = ((POSITION_WIDTH > CntW) ? POSITION_WIDTH : CntW) + 1;
  localparam logic [AddrW-1:0] LastAddr = AddrW'(MAX_WINDOW - 1);
  localparam logic [CntW-1:0]  FullCnt  = CntW'(MAX_WINDOW);
  localparam logic [CntW-1:0]  OneCnt   = CntW'(1);

  q_state_e                  state_q, state_d;
  logic [AddrW-1:0]          head_q, head_d;
  logic [AddrW-1:0]          tail_q, tail_d;
  logic [CntW-1:0]           count_q, count_d;
  logic [SAMPLE_WIDTH-1:0]   head_val_q, head_val_d;
  logic                      done_q, done_d;

  logic [EntryW-1:0]         mem_q [MAX_WINDOW];
  logic [EntryW-1:0]         rd_data_q;
  logic [AddrW-1:0]          rd_addr;
  logic                      mem_we;

  logic [SAMPLE_WIDTH-1:0]   rd_val;
  logic [POSITION_WIDTH-1:0] rd_pos;
  logic                      expire;
  logic                      pop;
  logic                      full;
  logic [AddrW-1:0]          head_inc;
  logic [AddrW-1:0]          tail_inc;
  logic [AddrW-1:0]          tail_dec;
  logic [AddrW-1:0]          tail_dec2;

  function automatic logic [AddrW-1:0] wrap_inc(input logic [AddrW-1:0] a);
    return (a == LastAddr) ? '0 : a + AddrW'(1);
  endfunction

  function automatic logic [AddrW-1:0] wrap_dec(input logic [AddrW-1:0] a);
    return (a == '0) ? LastAddr : a - AddrW'(1);
  endfunction

  // Entry fields as they come out of the read register.
  assign rd_val    = rd_data_q[EntryW-1:POSITION_WIDTH];
  assign rd_pos    = rd_data_q[POSITION_WIDTH-1:0];
  assign expire    = (SumW'(rd_pos) + SumW'(len_i)) <= SumW'(pos_i);
  assign pop       = keep_min_i ? (rd_val >= value_i) : (rd_val <= value_i);
  assign full      = (count_q == FullCnt);
  assign head_inc  = wrap_inc(head_q);
  assign tail_inc  = wrap_inc(tail_q);
  assign tail_dec  = wrap_dec(tail_q);
  assign tail_dec2 = wrap_dec(tail_dec);

  // Entry RAM: one write port at the tail and one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[tail_q] <= {value_i, pos_i};
    end
    rd_data_q <= mem_q[rd_addr];
  end

  // Sequencer: expire at the head, pop at the tail, append, report the head.
  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    tail_d     = tail_q;
    count_d    = count_q;
    head_val_d = head_val_q;
    done_d     = 1'b0;
    rd_addr    = head_q;
    mem_we     = 1'b0;
    unique case (state_q)
      Q_IDLE: begin
        if (ctl_i.clear) begin
          head_d  = '0;
          tail_d  = '0;
          count_d = '0;
        end else if (ctl_i.start) begin
          state_d = (count_q == '0) ? Q_WRITE : Q_EXP;
        end
      end
      Q_EXP: begin
        if (expire) begin
          head_d  = head_inc;
          count_d = count_q - OneCnt;
          rd_addr = head_inc;
          if (count_q == OneCnt) begin
            state_d = Q_WRITE;
          end
        end else begin
          // The surviving head is known now; pops only matter if they empty the queue.
          head_val_d = rd_val;
          rd_addr    = tail_dec;
          state_d    = Q_POP;
        end
      end
      Q_POP: begin
        if (pop) begin
          tail_d  = tail_dec;
          count_d = count_q - OneCnt;
          rd_addr = tail_dec2;
          if (count_q == OneCnt) begin
            state_d = Q_WRITE;
          end
        end else begin
          state_d = Q_WRITE;
        end
      end
      Q_WRITE: begin
        mem_we = 1'b1;
        tail_d = tail_inc;
        if (full) begin
          // A full queue drops its oldest entry to make room.
          head_d  = head_inc;
          rd_addr = head_inc;
        end else begin
          count_d = count_q + OneCnt;
        end
        if (full ? (MAX_WINDOW == 1) : (count_q == '0)) begin
          head_val_d = value_i;
          done_d     = 1'b1;
          state_d    = Q_IDLE;
        end else if (full) begin
          state_d = Q_HEAD;
        end else begin
          done_d  = 1'b1;
          state_d = Q_IDLE;
        end
      end
      Q_HEAD: begin
        head_val_d = rd_val;
        done_d     = 1'b1;
        state_d    = Q_IDLE;
      end
      default: begin
        state_d = Q_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= Q_IDLE;
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  // Head value register.
  always_ff @(posedge clk_i) begin
    head_val_q <= head_val_d;
  end

  assign done_o       = done_q;
  assign head_value_o = head_val_q;

  // The occupancy never exceeds the RAM depth.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCnt)
    else $error("queue occupancy above depth");

  // An empty queue has its head and tail pointers together.
  a_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (head_q == tail_q))
    else $error("empty queue with split pointers");

  // Completion is flagged only on return to idle.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (state_q == Q_IDLE))
    else $error("queue done outside idle");

endmodule
`default_nettype wire

FILE: sv/window_spread_detector.sv
`default_nettype none
// Flow: a sample request puts the sequencer in CTL_WAIT while both queues
// expire, pop and append (a full queue also drops its oldest entry and rereads
// its head), then CTL_EVAL judges the window and registers any result.
// Samples are taken only in CTL_IDLE, so a new one waits for the last to finish;
// each queue's RAM read port walks one entry per cycle, and a waiting result
// holds off the next request. Reset: asynchronous, active low; control and config registers.
// ----------------------------------------------------------------------------
// Window spread detector
// Tracks the minimum and maximum of the most recent window_len samples with
// two monotonic queues and reports the start of each window whose spread is
// within max_spread, or that no window matched at the end of the stream.
// ----------------------------------------------------------------------------
module window_spread_detector #(
  parameter int unsigned MAX_WINDOW     = 1024,
  parameter int unsigned POSITION_WIDTH = 20,
  parameter int unsigned SAMPLE_WIDTH   = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [wsd_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [wsd_pkg::CfgDataW-1:0]  cfg_data_i,
  wsd_smp_if.sink                       smp_i,
  wsd_res_if.source                     res_o
);
  import wsd_pkg::*;

  localparam int unsigned LenW  = $clog2(MAX_WINDOW + 1);
  localparam int unsigned CmpW  = (LenW > WinLenW) ? LenW : WinLenW;
  localparam int unsigned SumW  = ((POSITION_WIDTH > LenW) ? POSITION_WIDTH : LenW) + 1;
  localparam int unsigned DiffW = (SAMPLE_WIDTH > SpreadW) ? SAMPLE_WIDTH : SpreadW;
  localparam logic [POSITION_WIDTH-1:0] PosMax = {POSITION_WIDTH{1'b1}};

  ctl_state_e                state_q, state_d;
  logic [1:0]                seen_q, seen_d;
  logic [POSITION_WIDTH-1:0] pos_q, pos_d;
  logic                      found_q, found_d;
  logic                      out_valid_q, out_valid_d;
  logic [WinLenW-1:0]        win_len_q;
  logic [SpreadW-1:0]        max_spread_q;

  logic [SAMPLE_WIDTH-1:0]   smp_val_q;
  logic                      last_q;
  logic [LenW-1:0]           len_q;
  logic [POSITION_WIDTH-1:0] out_start_q;
  logic                      out_none_q;

  qctl_t                     qctl;
  logic                      min_done;
  logic                      max_done;
  logic [SAMPLE_WIDTH-1:0]   min_head;
  logic [SAMPLE_WIDTH-1:0]   max_head;

  logic                      smp_acc;
  logic [CmpW-1:0]           wl_ext;
  logic [LenW-1:0]           len_eff;
  logic [POSITION_WIDTH-1:0] pos_next;
  logic                      full_win;
  logic [SAMPLE_WIDTH-1:0]   spread;
  logic                      spread_ok;
  logic                      emit_match;
  logic                      emit_none;
  logic                      load;
  logic [POSITION_WIDTH-1:0] start_pos;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_len_q    <= WinLenW'(1);
      max_spread_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_WINDOW_LEN: win_len_q    <= cfg_data_i[WinLenW-1:0];
        CFG_MAX_SPREAD: max_spread_q <= cfg_data_i[SpreadW-1:0];
      endcase
    end
  end

  // Effective window length: zero means one, and it saturates at the depth.
  assign wl_ext  = CmpW'(win_len_q);
  assign len_eff = (win_len_q == '0)             ? LenW'(1) :
                   (wl_ext > CmpW'(MAX_WINDOW))  ? LenW'(MAX_WINDOW) :
                                                   LenW'(wl_ext);
  assign pos_next = (pos_q == PosMax) ? pos_q : pos_q + POSITION_WIDTH'(1);

  // Window check on the two queue heads.
  assign full_win   = SumW'(pos_q) >= SumW'(len_q);
  assign spread     = (max_head >= min_head) ? (max_head - min_head) : '0;
  assign spread_ok  = DiffW'(spread) <= DiffW'(max_spread_q);
  assign emit_match = full_win && spread_ok;
  assign emit_none  = last_q && !found_q && !emit_match;
  assign start_pos  = POSITION_WIDTH'(SumW'(pos_q) - SumW'(len_q) + SumW'(1));

  assign smp_i.ready = (state_q == CTL_IDLE);
  assign smp_acc     = smp_i.valid && (state_q == CTL_IDLE);

  // Sequencer: take a sample, run both queues, then judge the window.
  always_comb begin
    state_d     = state_q;
    seen_d      = seen_q;
    pos_d       = pos_q;
    found_d     = found_q;
    qctl        = '0;
    load        = 1'b0;
    unique case (state_q)
      CTL_IDLE: begin
        if (smp_acc) begin
          qctl.start = 1'b1;
          pos_d      = pos_next;
          seen_d     = '0;
          state_d    = CTL_WAIT;
        end
      end
      CTL_WAIT: begin
        seen_d = seen_q | {max_done, min_done};
        if (&seen_d) begin
          state_d = CTL_EVAL;
        end
      end
      CTL_EVAL: begin
        // A result waits here until the output register is free.
        if (!(emit_match || emit_none) || !out_valid_q || res_o.ready) begin
          load = emit_match || emit_none;
          if (emit_match) begin
            found_d = 1'b1;
          end
          if (last_q) begin
            pos_d      = '0;
            found_d    = 1'b0;
            qctl.clear = 1'b1;
          end
          state_d = CTL_IDLE;
        end
      end
      default: begin
        state_d = CTL_IDLE;
      end
    endcase
  end

  assign out_valid_d = load || (out_valid_q && !res_o.ready);

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= CTL_IDLE;
      seen_q      <= '0;
      pos_q       <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      seen_q      <= seen_d;
      pos_q       <= pos_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Sample and result payload registers.
  always_ff @(posedge clk_i) begin
    if (smp_acc) begin
      smp_val_q <= smp_i.sample;
      last_q    <= smp_i.last_sample;
      len_q     <= len_eff;
    end
    if (load) begin
      out_start_q <= emit_match ? start_pos : '0;
      out_none_q  <= !emit_match;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.window_start = out_start_q;
  assign res_o.none_found   = out_none_q;

  // Minimum queue: values rise from head to tail.
  wsd_mono_queue #(
    .MAX_WINDOW     (MAX_WINDOW),
    .POSITION_WIDTH (POSITION_WIDTH),
    .SAMPLE_WIDTH   (SAMPLE_WIDTH)
  ) u_min_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .keep_min_i   (1'b1),
    .ctl_i        (qctl),
    .value_i      (smp_val_q),
    .pos_i        (pos_q),
    .len_i        (len_q),
    .done_o       (min_done),
    .head_value_o (min_head)
  );

  // Maximum queue: values fall from head to tail.
  wsd_mono_queue #(
    .MAX_WINDOW     (MAX_WINDOW),
    .POSITION_WIDTH (POSITION_WIDTH),
    .SAMPLE_WIDTH   (SAMPLE_WIDTH)
  ) u_max_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .keep_min_i   (1'b0),
    .ctl_i        (qctl),
    .value_i      (smp_val_q),
    .pos_i        (pos_q),
    .len_i        (len_q),
    .done_o       (max_done),
    .head_value_o (max_head)
  );

  // The queues only finish work that the sequencer started.
  a_no_stray_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == CTL_IDLE) |-> !(min_done || max_done))
    else $error("queue finished while sequencer idle");

  // The end of a stream restarts the position and the match flag.
  a_stream_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == CTL_EVAL && last_q && state_d == CTL_IDLE) |=> (pos_q == '0 && !found_q))
    else $error("stream state kept after last sample");

  // A no-match result carries no start position.
  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.none_found) |-> (res_o.window_start == '0))
    else $error("none_found result with a start position");

endmodule
`default_nettype wire
